>>> sv/lstc_pkg.sv
// ----------------------------------------------------------------------------
// lstc_pkg
// Shared types, constants and the arctangent table for the laser scan to
// Cartesian point pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lstc_pkg;

    localparam int unsigned DEF_MAX_SAMPLES   = 4096;
    localparam int unsigned DEF_CORDIC_STAGES = 20;

    localparam int unsigned RANGE_W = 24;
    localparam int unsigned INDEX_W = 12;
    localparam int unsigned COORD_W = 25;
    localparam int unsigned PHASE_W = 32;
    localparam int unsigned XW      = 43;   // CORDIC vector, Q12.28 plus growth
    localparam int unsigned ZW      = 33;   // residual angle accumulator
    localparam int unsigned APB_AW  = 5;

    localparam logic [30:0] GAIN_Q31 = 31'd1304065748;

    localparam logic [2:0] CFG_START_ANGLE   = 3'd0;
    localparam logic [2:0] CFG_ANGLE_STEP    = 3'd1;
    localparam logic [2:0] CFG_MIN_RANGE     = 3'd2;
    localparam logic [2:0] CFG_MAX_RANGE     = 3'd3;
    localparam logic [2:0] CFG_SENSOR_HEIGHT = 3'd4;

    localparam logic [1:0] QUARTER_0 = 2'd0;
    localparam logic [1:0] QUARTER_1 = 2'd1;
    localparam logic [1:0] QUARTER_2 = 2'd2;
    localparam logic [1:0] QUARTER_3 = 2'd3;

    localparam logic signed [XW-1:0] ROUND_HALF  = XW'(32768);
    localparam logic signed [XW-1:0] COORD_LIMIT = XW'(16777215);

    typedef struct packed {
        logic        [1:0]    quarter;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_lane_t;

    function automatic logic [PHASE_W-1:0] atan_phase(input logic [4:0] idx);
        logic [PHASE_W-1:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd41;
            5'd25:   v = 32'd20;
            5'd26:   v = 32'd10;
            5'd27:   v = 32'd5;
            5'd28:   v = 32'd3;
            5'd29:   v = 32'd1;
            5'd30:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Q12.28 -> Q12.12, round half up, saturate symmetric
    function automatic logic signed [COORD_W-1:0] to_q12(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        logic signed [XW-1:0] s;
        r = (v + ROUND_HALF) >>> 16;
        if (r > COORD_LIMIT)
            s = COORD_LIMIT;
        else if (r < -COORD_LIMIT)
            s = -COORD_LIMIT;
        else
            s = r;
        return s[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/laser_scan_to_cartesian.sv
// ----------------------------------------------------------------------------
// laser_scan_to_cartesian
// Projects laser range samples to Cartesian points with a pipelined CORDIC.
//
// Channel  Direction  Handshake                  Payload
// request  in         start & !busy              range_value, is_finite,
//                                                sample_index
// result   out        result_valid (1 cycle)     point_x, point_y, point_z
// config   in         APB, psel&penable&pwrite   start_angle .. sensor_height
//
// One request per clock; busy is always low.
// Path from accept to result strobe: input capture, filter, angle, CORDIC stages, quarter-turn rotation, output.
// Throughput is set by the fully pipelined CORDIC chain, each stage registered.
// Rejected samples travel as bubbles and give no strobe.
// Reset clears valid bits and configuration, but sets max_range to all ones; no clearing pass.
// The receiver cannot stall the block.
// ----------------------------------------------------------------------------
`default_nettype none

module laser_scan_to_cartesian
    import lstc_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES   = DEF_MAX_SAMPLES,
    parameter int unsigned CORDIC_STAGES = DEF_CORDIC_STAGES
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic        [RANGE_W-1:0] range_value,
    input  wire logic                      is_finite,
    input  wire logic        [INDEX_W-1:0] sample_index,
    output logic                           result_valid,
    output logic signed      [COORD_W-1:0] point_x,
    output logic signed      [COORD_W-1:0] point_y,
    output logic signed      [COORD_W-1:0] point_z,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic        [APB_AW-1:0]  paddr,
    input  wire logic        [31:0]        pwdata,
    output logic             [31:0]        prdata,
    output logic                           pready
);

    localparam int unsigned NSTG = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int unsigned LAT  = NSTG + 5;

    // configuration
    logic [PHASE_W-1:0] start_angle_reg;
    logic [PHASE_W-1:0] angle_step_reg;
    logic [RANGE_W-1:0] min_range_reg;
    logic [RANGE_W-1:0] max_range_reg;
    logic [COORD_W-1:0] sensor_height_reg;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_angle_reg   <= '0;
            angle_step_reg    <= '0;
            min_range_reg     <= '0;
            max_range_reg     <= '1;
            sensor_height_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                CFG_START_ANGLE:   start_angle_reg   <= pwdata;
                CFG_ANGLE_STEP:    angle_step_reg    <= pwdata;
                CFG_MIN_RANGE:     min_range_reg     <= pwdata[RANGE_W-1:0];
                CFG_MAX_RANGE:     max_range_reg     <= pwdata[RANGE_W-1:0];
                CFG_SENSOR_HEIGHT: sensor_height_reg <= pwdata[COORD_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            CFG_START_ANGLE:   prdata = start_angle_reg;
            CFG_ANGLE_STEP:    prdata = angle_step_reg;
            CFG_MIN_RANGE:     prdata = {8'd0, min_range_reg};
            CFG_MAX_RANGE:     prdata = {8'd0, max_range_reg};
            CFG_SENSOR_HEIGHT: prdata = {{7{sensor_height_reg[COORD_W-1]}},
                                         sensor_height_reg};
            default:           prdata = '0;
        endcase
    end

    // stage 0: input capture
    logic               s0_valid_reg;
    logic [RANGE_W-1:0] s0_range_reg;
    logic               s0_finite_reg;
    logic [INDEX_W-1:0] s0_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= start & ~busy;
    end

    always_ff @(posedge clk)
    begin
        s0_range_reg  <= range_value;
        s0_finite_reg <= is_finite;
        s0_index_reg  <= sample_index;
    end

    // stage 1: filter, index*step, range*gain
    logic                 s1_valid_next;
    logic                 s1_valid_reg;
    logic [PHASE_W-1:0]   s1_prod_reg;
    logic signed [XW-1:0] s1_x0_reg;
    logic [54:0]          gain_prod;
    logic [43:0]          step_prod;

    assign s1_valid_next = s0_valid_reg & s0_finite_reg
                         & (32'(s0_index_reg) < 32'(MAX_SAMPLES))
                         & (s0_range_reg >= min_range_reg)
                         & (s0_range_reg <= max_range_reg);
    assign gain_prod = 55'(s0_range_reg) * 55'(GAIN_Q31);
    assign step_prod = 44'(s0_index_reg) * 44'(angle_step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        s1_prod_reg <= step_prod[PHASE_W-1:0];
        s1_x0_reg   <= $signed({3'b000, gain_prod[54:15]});
    end

    // stage 2: angle, quarter turn and residual
    logic [PHASE_W-1:0] angle;
    logic [PHASE_W-1:0] angle_ofs;
    logic               s2_valid_reg;
    cordic_lane_t       s2_lane_reg;
    cordic_lane_t       s2_lane_next;

    assign angle     = start_angle_reg + s1_prod_reg;
    assign angle_ofs = angle + 32'h2000_0000;

    always_comb
    begin
        s2_lane_next.quarter = angle_ofs[31:30];
        s2_lane_next.x       = s1_x0_reg;
        s2_lane_next.y       = '0;
        s2_lane_next.z       = $signed({{4{~angle_ofs[29]}}, angle_ofs[28:0]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_lane_reg <= s2_lane_next;
    end

    // CORDIC chain
    logic         chain_valid [NSTG+1];
    cordic_lane_t chain_lane  [NSTG+1];

    assign chain_valid[0] = s2_valid_reg;
    assign chain_lane[0]  = s2_lane_reg;

    for (genvar g = 0; g < NSTG; g++)
    begin : g_cordic
        lstc_cordic_stage #(
            .STAGE_IDX (g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (chain_valid[g]),
            .lane_in   (chain_lane[g]),
            .valid_out (chain_valid[g+1]),
            .lane_out  (chain_lane[g+1])
        );
    end

    // quarter-turn rotation
    cordic_lane_t         fin_lane;
    logic                 rot_valid_reg;
    logic signed [XW-1:0] rot_x_reg;
    logic signed [XW-1:0] rot_y_reg;
    logic signed [XW-1:0] rot_x_next;
    logic signed [XW-1:0] rot_y_next;

    assign fin_lane = chain_lane[NSTG];

    always_comb
    begin
        case (fin_lane.quarter)
            QUARTER_0:
            begin
                rot_x_next = fin_lane.x;
                rot_y_next = fin_lane.y;
            end
            QUARTER_1:
            begin
                rot_x_next = -fin_lane.y;
                rot_y_next = fin_lane.x;
            end
            QUARTER_2:
            begin
                rot_x_next = -fin_lane.x;
                rot_y_next = -fin_lane.y;
            end
            default:
            begin
                rot_x_next = fin_lane.y;
                rot_y_next = -fin_lane.x;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rot_valid_reg <= 1'b0;
        else
            rot_valid_reg <= chain_valid[NSTG];
    end

    always_ff @(posedge clk)
    begin
        rot_x_reg <= rot_x_next;
        rot_y_reg <= rot_y_next;
    end

    // output: round, saturate
    logic                      out_valid_reg;
    logic signed [COORD_W-1:0] out_x_reg;
    logic signed [COORD_W-1:0] out_y_reg;
    logic signed [COORD_W-1:0] out_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= rot_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        out_x_reg <= to_q12(rot_x_reg);
        out_y_reg <= to_q12(rot_y_reg);
        out_z_reg <= $signed(sensor_height_reg);
    end

    assign result_valid = out_valid_reg;
    assign point_x      = out_x_reg;
    assign point_y      = out_y_reg;
    assign point_z      = out_z_reg;

`ifndef SYNTHESIS
    a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, LAT))
        else $error("result without matching request");

    a_result_was_finite: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(is_finite, LAT))
        else $error("result from non-finite sample");

    a_result_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (point_x != 25'sh1000000) && (point_y != 25'sh1000000))
        else $error("coordinate outside saturation limits");
`endif

endmodule

`default_nettype wire

>>> sv/lstc_cordic_stage.sv
// ----------------------------------------------------------------------------
// lstc_cordic_stage
// One registered rotation-mode CORDIC micro-rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module lstc_cordic_stage
    import lstc_pkg::*;
#(
    parameter int unsigned STAGE_IDX = 0
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         valid_in,
    input  wire cordic_lane_t lane_in,
    output logic              valid_out,
    output cordic_lane_t      lane_out
);

    localparam logic [4:0] SHIFT = 5'(STAGE_IDX);

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] dz;
    logic                 valid_reg;
    cordic_lane_t         lane_reg;
    cordic_lane_t         lane_next;

    assign dx = lane_in.y >>> SHIFT;
    assign dy = lane_in.x >>> SHIFT;
    assign dz = $signed({1'b0, atan_phase(SHIFT)});

    always_comb
    begin
        lane_next.quarter = lane_in.quarter;
        if (!lane_in.z[ZW-1])
        begin
            lane_next.x = lane_in.x - dx;
            lane_next.y = lane_in.y + dy;
            lane_next.z = lane_in.z - dz;
        end
        else
        begin
            lane_next.x = lane_in.x + dx;
            lane_next.y = lane_in.y - dy;
            lane_next.z = lane_in.z + dz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign valid_out = valid_reg;
    assign lane_out  = lane_reg;

endmodule

`default_nettype wire
